[hw/rtl/hfx_pkg.sv]
`timescale 1ns / 1ps

package hfx_pkg;

  // Content type capture depth in bytes (1..24)
  localparam int unsigned TYPE_MAX = 19;

  localparam int unsigned TYPE_LEN_W  = 5;
  localparam int unsigned TYPE_WORD_W = 64;

  localparam logic [9:0]  STATUS_SAT = 10'd999;
  localparam logic [30:0] LENGTH_SAT = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [9:0]              status_code;
    logic                    status_found;
    logic [30:0]             content_length;
    logic                    length_found;
    logic                    type_found;
    logic                    type_closed;
    logic [TYPE_LEN_W-1:0]   type_length;
    logic [TYPE_WORD_W-1:0]  type_bytes_lo;
    logic [TYPE_WORD_W-1:0]  type_bytes_mid;
    logic [TYPE_WORD_W-1:0]  type_bytes_hi;
  } hfx_result_t;

endpackage

[hw/rtl/hfx_core.sv]
`timescale 1ns / 1ps

module hfx_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          header_byte_i,
  input  logic                frame_end_i,
  output hfx_pkg::hfx_result_t result_o
);
  import hfx_pkg::*;

  typedef enum logic [1:0] {PH_SEARCH, PH_SEEK, PH_SKIPWS, PH_DIGITS} num_phase_e;
  typedef enum logic [1:0] {TP_SEARCH, TP_SEEK, TP_CAPTURE} type_phase_e;

  // keywords, first char at index 0, zero padded to the counter range
  localparam logic [0:7][7:0]  KW_STATUS = {"HTTP", 32'h0};
  localparam logic [0:15][7:0] KW_LENGTH = {"Content-Length", 16'h0};
  localparam logic [0:15][7:0] KW_TYPE   = {"Content-Type", 32'h0};

  localparam logic [2:0] ST_KW_LEN = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;
  localparam logic [3:0] LN_KW_LEN = 4'd14;
  localparam logic [3:0] LN_DONE   = 4'd15;
  localparam logic [3:0] TY_KW_LEN = 4'd12;
  localparam logic [3:0] TY_DONE   = 4'd13;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) ||
            (b == 8'h0C) || (b == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  logic [2:0]  st_pos_q, st_pos_d;
  num_phase_e  st_ph_q, st_ph_d;
  logic [9:0]  st_val_q, st_val_d;
  logic [3:0]  ln_pos_q, ln_pos_d;
  num_phase_e  ln_ph_q, ln_ph_d;
  logic [30:0] ln_val_q, ln_val_d;
  logic [3:0]  ty_pos_q, ty_pos_d;
  type_phase_e ty_ph_q, ty_ph_d;
  logic [TYPE_LEN_W-1:0] ty_cnt_q, ty_cnt_d;
  logic [7:0]  ty_store_q [TYPE_MAX];
  logic [7:0]  ty_store_d [TYPE_MAX];
  logic        ty_wr;

  logic [7:0]  b;
  logic        b_digit;
  logic [3:0]  digit;
  logic [13:0] st_mul;
  logic [34:0] ln_mul;
  logic [3*TYPE_WORD_W-1:0] ty_words;

  assign b       = header_byte_i;
  assign b_digit = is_digit(b);
  assign digit   = b[3:0];
  assign st_mul  = ({4'b0, st_val_q} << 3) + ({4'b0, st_val_q} << 1) + {10'b0, digit};
  assign ln_mul  = ({4'b0, ln_val_q} << 3) + ({4'b0, ln_val_q} << 1) + {31'b0, digit};

  // status matcher
  always_comb begin
    st_pos_d = st_pos_q;
    st_ph_d  = st_ph_q;
    st_val_d = st_val_q;
    if (st_pos_q < ST_KW_LEN) begin
      if (b == KW_STATUS[st_pos_q]) begin
        st_pos_d = st_pos_q + 3'd1;
      end else if (b == KW_STATUS[0]) begin
        st_pos_d = 3'd1;
      end else begin
        st_pos_d = 3'd0;
      end
      if (st_pos_d == ST_KW_LEN) begin
        st_ph_d = PH_SEEK;
      end
    end else if (st_pos_q == ST_KW_LEN) begin
      unique case (st_ph_q)
        PH_SEEK: begin
          if (b == CH_SPACE) begin
            st_ph_d = PH_SKIPWS;
          end
        end
        PH_SKIPWS: begin
          if (b_digit) begin
            st_val_d = {6'b0, digit};
            st_ph_d  = PH_DIGITS;
          end else if (!is_ws(b)) begin
            st_pos_d = ST_DONE;
          end
        end
        PH_DIGITS: begin
          if (b_digit) begin
            st_val_d = (st_mul > {4'b0, STATUS_SAT}) ? STATUS_SAT : st_mul[9:0];
          end else begin
            st_pos_d = ST_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // content length matcher
  always_comb begin
    ln_pos_d = ln_pos_q;
    ln_ph_d  = ln_ph_q;
    ln_val_d = ln_val_q;
    if (ln_pos_q < LN_KW_LEN) begin
      if (b == KW_LENGTH[ln_pos_q]) begin
        ln_pos_d = ln_pos_q + 4'd1;
      end else if (b == KW_LENGTH[0]) begin
        ln_pos_d = 4'd1;
      end else begin
        ln_pos_d = 4'd0;
      end
      if (ln_pos_d == LN_KW_LEN) begin
        ln_ph_d = PH_SEEK;
      end
    end else if (ln_pos_q == LN_KW_LEN) begin
      unique case (ln_ph_q)
        PH_SEEK: begin
          if (b == CH_SPACE) begin
            ln_ph_d = PH_SKIPWS;
          end
        end
        PH_SKIPWS: begin
          if (b_digit) begin
            ln_val_d = {27'b0, digit};
            ln_ph_d  = PH_DIGITS;
          end else if (!is_ws(b)) begin
            ln_pos_d = LN_DONE;
          end
        end
        PH_DIGITS: begin
          if (b_digit) begin
            ln_val_d = (|ln_mul[34:31]) ? LENGTH_SAT : ln_mul[30:0];
          end else begin
            ln_pos_d = LN_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // content type matcher and capture
  always_comb begin
    ty_pos_d = ty_pos_q;
    ty_ph_d  = ty_ph_q;
    ty_cnt_d = ty_cnt_q;
    ty_wr    = 1'b0;
    if (ty_pos_q < TY_KW_LEN) begin
      if (b == KW_TYPE[ty_pos_q]) begin
        ty_pos_d = ty_pos_q + 4'd1;
      end else if (b == KW_TYPE[0]) begin
        ty_pos_d = 4'd1;
      end else begin
        ty_pos_d = 4'd0;
      end
      if (ty_pos_d == TY_KW_LEN) begin
        ty_ph_d = TP_SEEK;
      end
    end else if (ty_pos_q == TY_KW_LEN) begin
      unique case (ty_ph_q)
        TP_SEEK: begin
          if (b == CH_SPACE) begin
            ty_ph_d = TP_CAPTURE;
          end
        end
        TP_CAPTURE: begin
          if (b == CH_SEMI) begin
            ty_pos_d = TY_DONE;
          end else if (ty_cnt_q < TYPE_LEN_W'(TYPE_MAX)) begin
            ty_wr    = 1'b1;
            ty_cnt_d = ty_cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // capture store with this byte folded in, then packed for the result
  always_comb begin
    ty_words = '0;
    for (int k = 0; k < TYPE_MAX; k++) begin
      ty_store_d[k] = (ty_wr && ty_cnt_q == TYPE_LEN_W'(k)) ? b : ty_store_q[k];
      if (TYPE_LEN_W'(k) < ty_cnt_d) begin
        ty_words[8*k +: 8] = ty_store_d[k];
      end
    end
  end

  always_comb begin
    result_o.status_code    = st_val_d;
    result_o.status_found   = (st_pos_d >= ST_KW_LEN);
    result_o.content_length = ln_val_d;
    result_o.length_found   = (ln_pos_d >= LN_KW_LEN);
    result_o.type_found     = (ty_pos_d >= TY_KW_LEN);
    result_o.type_closed    = (ty_pos_d == TY_DONE);
    result_o.type_length    = ty_cnt_d;
    result_o.type_bytes_lo  = ty_words[0 +: TYPE_WORD_W];
    result_o.type_bytes_mid = ty_words[TYPE_WORD_W +: TYPE_WORD_W];
    result_o.type_bytes_hi  = ty_words[2*TYPE_WORD_W +: TYPE_WORD_W];
  end

  // matcher state; a frame end returns everything to idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_pos_q <= '0;
      st_ph_q  <= PH_SEARCH;
      st_val_q <= '0;
      ln_pos_q <= '0;
      ln_ph_q  <= PH_SEARCH;
      ln_val_q <= '0;
      ty_pos_q <= '0;
      ty_ph_q  <= TP_SEARCH;
      ty_cnt_q <= '0;
    end else if (step_i) begin
      if (frame_end_i) begin
        st_pos_q <= '0;
        st_ph_q  <= PH_SEARCH;
        st_val_q <= '0;
        ln_pos_q <= '0;
        ln_ph_q  <= PH_SEARCH;
        ln_val_q <= '0;
        ty_pos_q <= '0;
        ty_ph_q  <= TP_SEARCH;
        ty_cnt_q <= '0;
      end else begin
        st_pos_q <= st_pos_d;
        st_ph_q  <= st_ph_d;
        st_val_q <= st_val_d;
        ln_pos_q <= ln_pos_d;
        ln_ph_q  <= ln_ph_d;
        ln_val_q <= ln_val_d;
        ty_pos_q <= ty_pos_d;
        ty_ph_q  <= ty_ph_d;
        ty_cnt_q <= ty_cnt_d;
      end
    end
  end

  // entries past the fill count are masked on readout
  always_ff @(posedge clk_i) begin
    if (step_i && ty_wr) begin
      ty_store_q[ty_cnt_q[TYPE_LEN_W-1:0]] <= b;
    end
  end

endmodule

[hw/rtl/http_header_field_extractor.sv]
`timescale 1ns / 1ps
// HTTP response header field extractor.
//
// Input channel: one header byte per transfer (header_byte_i), with
// frame_end_i marking the last byte of a header buffer. A transfer happens
// on a rising edge with in_valid_i high and in_stall_o low.
// Output channel: one result transfer per buffer, carrying the status code,
// content length and up to TYPE_MAX bytes of content type text, each with
// its found flag. Transfer on out_valid_o high and out_stall_i low.
//
// Throughput: one byte per cycle while the input is not stalled. Each byte
// updates three small keyword matchers and their accumulators combinationally;
// the widest path is the content length multiply-by-ten and saturate.
// Result: the output register loads on the transfer of the final byte.
// Stall: the input stalls only while a finished result is held and the
// receiver stalls; the held result does not change.
// Reset: all matchers return to searching and the output register empties.
// Matchers also return to searching after every final byte.

module http_header_field_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  header_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  status_code_o,
  output logic        status_found_o,
  output logic [30:0] content_length_o,
  output logic        length_found_o,
  output logic        type_found_o,
  output logic        type_closed_o,
  output logic [4:0]  type_length_o,
  output logic [63:0] type_bytes_lo_o,
  output logic [63:0] type_bytes_mid_o,
  output logic [63:0] type_bytes_hi_o
);
  import hfx_pkg::*;

  logic        in_xfer;
  logic        out_valid_q;
  hfx_result_t res_next;
  hfx_result_t res_q;

  // the output register frees up on the same edge it is read
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  hfx_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_xfer),
    .header_byte_i (header_byte_i),
    .frame_end_i   (frame_end_i),
    .result_o      (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && frame_end_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded on the final byte of a buffer
  always_ff @(posedge clk_i) begin
    if (in_xfer && frame_end_i) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_code_o    = res_q.status_code;
  assign status_found_o   = res_q.status_found;
  assign content_length_o = res_q.content_length;
  assign length_found_o   = res_q.length_found;
  assign type_found_o     = res_q.type_found;
  assign type_closed_o    = res_q.type_closed;
  assign type_length_o    = res_q.type_length;
  assign type_bytes_lo_o  = res_q.type_bytes_lo;
  assign type_bytes_mid_o = res_q.type_bytes_mid;
  assign type_bytes_hi_o  = res_q.type_bytes_hi;

endmodule

[hw/rtl/hfx_checker.sv]
`timescale 1ns / 1ps

module hfx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        frame_end_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [9:0]  status_code_o,
  input logic        status_found_o,
  input logic [30:0] content_length_o,
  input logic        length_found_o,
  input logic        type_found_o,
  input logic        type_closed_o,
  input logic [4:0]  type_length_o,
  input logic [63:0] type_bytes_lo_o,
  input logic [63:0] type_bytes_mid_o,
  input logic [63:0] type_bytes_hi_o
);
  import hfx_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_code_o) &&
      $stable(content_length_o) && $stable(type_length_o) && $stable(type_bytes_lo_o) &&
      $stable(type_bytes_mid_o) && $stable(type_bytes_hi_o))
    else $error("result changed while stalled");

  // a final byte always produces a result next cycle
  a_frame_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && frame_end_i |=> out_valid_o)
    else $error("final byte gave no result");

  // values only where the keyword was seen, and within range
  a_fields_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_code_o <= STATUS_SAT &&
      (status_found_o || status_code_o == 10'd0) &&
      (length_found_o || content_length_o == 31'd0))
    else $error("number field inconsistent with found flag");

  a_type_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> type_length_o <= 5'(TYPE_MAX) &&
      (!type_closed_o || type_found_o) &&
      (type_found_o || (type_length_o == 5'd0 && type_bytes_lo_o == 64'd0)))
    else $error("content type fields inconsistent");

endmodule

bind http_header_field_extractor hfx_checker u_hfx_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

// Header field extractor bench: byte stream in, one summary per buffer out.
module tb;
  import hfx_pkg::*;

  // Keywords, right-aligned; character k sits at bits 8*(len-1-k)
  localparam logic [8*14-1:0] KW_STATUS = "HTTP";
  localparam logic [8*14-1:0] KW_LENGTH = "Content-Length";
  localparam logic [8*14-1:0] KW_TYPE   = "Content-Type";
  localparam int unsigned ST_KW_LEN = 4;
  localparam int unsigned LN_KW_LEN = 14;
  localparam int unsigned TY_KW_LEN = 12;

  typedef enum logic [1:0] {NUM_SEARCH, NUM_SEEK, NUM_SKIP, NUM_DIGITS} num_phase_e;
  typedef enum logic [1:0] {TY_SEARCH, TY_SEEK, TY_CAPTURE} ty_phase_e;

  typedef struct packed {
    logic [7:0] hb;
    logic       fe;
  } hdr_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  header_byte_i = 8'h00;
  logic        frame_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  status_code_o;
  logic        status_found_o;
  logic [30:0] content_length_o;
  logic        length_found_o;
  logic        type_found_o;
  logic        type_closed_o;
  logic [4:0]  type_length_o;
  logic [63:0] type_bytes_lo_o;
  logic [63:0] type_bytes_mid_o;
  logic [63:0] type_bytes_hi_o;

  http_header_field_extractor u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .header_byte_i   (header_byte_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_code_o   (status_code_o),
    .status_found_o  (status_found_o),
    .content_length_o(content_length_o),
    .length_found_o  (length_found_o),
    .type_found_o    (type_found_o),
    .type_closed_o   (type_closed_o),
    .type_length_o   (type_length_o),
    .type_bytes_lo_o (type_bytes_lo_o),
    .type_bytes_mid_o(type_bytes_mid_o),
    .type_bytes_hi_o (type_bytes_hi_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Shadow matcher state, advanced once per accepted input transfer
  // ---------------------------------------------------------------------
  logic [3:0]   st_pos, ln_pos, ty_pos;
  num_phase_e   st_phase, ln_phase;
  ty_phase_e    ty_phase;
  logic [31:0]  st_val, ln_val;
  logic [4:0]   ty_count;
  logic [191:0] ty_text;           // captured byte k at [8*k +: 8]

  hfx_result_t  summary_q[$];      // summaries owed by the block, oldest first

  task automatic clear_matchers();
    st_pos = '0; st_phase = NUM_SEARCH; st_val = '0;
    ln_pos = '0; ln_phase = NUM_SEARCH; ln_val = '0;
    ty_pos = '0; ty_phase = TY_SEARCH; ty_count = '0; ty_text = '0;
  endtask

  // Plain restart on mismatch: only the first keyword char can restart a match
  function automatic logic [3:0] kw_next(input logic [3:0] pos, input logic [8*14-1:0] kw,
                                         input int unsigned len, input logic [7:0] b);
    if (b == kw[8*(len-1-pos) +: 8]) return pos + 4'd1;
    return (b == kw[8*(len-1) +: 8]) ? 4'd1 : 4'd0;
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // seek space -> skip whitespace -> digits; anything else ends the field
  task automatic num_scan(inout logic [3:0] pos, input int unsigned len,
                          inout num_phase_e ph, inout logic [31:0] val,
                          input logic [31:0] sat, input logic [7:0] b);
    logic [63:0] acc;
    if (pos != len) return;
    case (ph)
      NUM_SEEK: begin
        if (b == " ") ph = NUM_SKIP;
      end
      NUM_SKIP: begin
        if (b inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D}) begin
        end else if (is_digit(b)) begin
          val = 32'(b - "0");
          ph  = NUM_DIGITS;
        end else begin
          pos = 4'(len + 1);
        end
      end
      NUM_DIGITS: begin
        if (is_digit(b)) begin
          acc = 64'(val) * 64'd10 + 64'(b - "0");
          val = (acc > 64'(sat)) ? sat : acc[31:0];
        end else begin
          pos = 4'(len + 1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    hfx_result_t r;
    if (st_pos < ST_KW_LEN) begin
      st_pos = kw_next(st_pos, KW_STATUS, ST_KW_LEN, b);
      if (st_pos == ST_KW_LEN) st_phase = NUM_SEEK;
    end else begin
      num_scan(st_pos, ST_KW_LEN, st_phase, st_val, 32'(STATUS_SAT), b);
    end

    if (ln_pos < LN_KW_LEN) begin
      ln_pos = kw_next(ln_pos, KW_LENGTH, LN_KW_LEN, b);
      if (ln_pos == LN_KW_LEN) ln_phase = NUM_SEEK;
    end else begin
      num_scan(ln_pos, LN_KW_LEN, ln_phase, ln_val, 32'(LENGTH_SAT), b);
    end

    if (ty_pos < TY_KW_LEN) begin
      ty_pos = kw_next(ty_pos, KW_TYPE, TY_KW_LEN, b);
      if (ty_pos == TY_KW_LEN) ty_phase = TY_SEEK;
    end else if (ty_pos == TY_KW_LEN) begin
      if (ty_phase == TY_SEEK) begin
        if (b == " ") ty_phase = TY_CAPTURE;
      end else if (ty_phase == TY_CAPTURE) begin
        if (b == ";") begin
          ty_pos = 4'(TY_KW_LEN + 1);
        end else if (ty_count < TYPE_MAX) begin
          ty_text[8*ty_count +: 8] = b;
          ty_count++;
        end
      end
    end

    if (!last) return;
    r.status_code    = st_val[9:0];
    r.status_found   = st_pos >= ST_KW_LEN;
    r.content_length = ln_val[30:0];
    r.length_found   = ln_pos >= LN_KW_LEN;
    r.type_found     = ty_pos >= TY_KW_LEN;
    r.type_closed    = ty_pos == TY_KW_LEN + 1;
    r.type_length    = ty_count;
    r.type_bytes_lo  = ty_text[63:0];
    r.type_bytes_mid = ty_text[127:64];
    r.type_bytes_hi  = ty_text[191:128];
    summary_q.push_back(r);
    clear_matchers();
  endtask

  // ---------------------------------------------------------------------
  // Stimulus: header buffers built from fragments, queued byte by byte
  // ---------------------------------------------------------------------
  hdr_byte_t   tx_q[$];
  logic [7:0]  frame_buf[$];
  int unsigned n_pushed = 0;
  int unsigned n_frames = 0;
  int unsigned n_sent = 0;
  int unsigned n_errors = 0;
  bit          drv_idle_en = 1'b1;
  bit          rcv_idle_en = 1'b1;

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endtask

  task automatic add_byte(input logic [7:0] b);
    frame_buf.push_back(b);
  endtask

  // Queue the assembled buffer; the last byte carries frame_end
  task automatic flush_frame();
    hdr_byte_t it;
    foreach (frame_buf[i]) begin
      it.hb = frame_buf[i];
      it.fe = (i == frame_buf.size() - 1);
      tx_q.push_back(it);
      n_pushed++;
    end
    frame_buf.delete();
    n_frames++;
  endtask

  task automatic add_gap_ws();
    logic [7:0] ws [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    if ($urandom_range(0, 19) < 17) add_byte(" ");
    repeat ($urandom_range(0, 2)) add_byte(ws[$urandom_range(0, 5)]);
  endtask

  // Mostly short numbers; long runs push both fields into saturation
  task automatic add_number();
    int unsigned nd;
    if ($urandom_range(0, 9) == 0) add_byte($urandom_range(0, 1) ? "+" : "-");
    nd = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    repeat (nd) add_byte(8'("0" + $urandom_range(0, 9)));
    if ($urandom_range(0, 1)) add_byte(" ");
  endtask

  task automatic gen_frame();
    string       kw;
    int unsigned n, cut;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          add_str($urandom_range(0, 1) ? "HTTP/1.1" : "HTTP");
          add_gap_ws();
          add_number();
        end
        2, 3: begin
          add_str("Content-Length:");
          add_gap_ws();
          add_number();
        end
        4, 5: begin
          add_str("Content-Type:");
          if ($urandom_range(0, 19) < 17) add_byte(" ");
          n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 24) : $urandom_range(0, 10);
          repeat (n) add_byte(8'($urandom_range(32, 126)));
          if ($urandom_range(0, 9) < 6) add_byte(";");
          if ($urandom_range(0, 1)) add_str(" charset=utf-8");
        end
        6: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
        7: begin
          // keyword cut short, possibly completed by a later fragment
          case ($urandom_range(0, 2))
            0: kw = "HTTP";
            1: kw = "Content-Length";
            default: kw = "Content-Type";
          endcase
          n = $urandom_range(1, kw.len() - 1);
          for (int i = 0; i < n; i++) add_byte(kw[i]);
        end
        8: begin
          add_str("HTTP ");
          add_byte($urandom_range(0, 1) ? "-" : "x");
          add_number();
        end
        default: add_str("\r\n");
      endcase
    end
    // sometimes the buffer ends in the middle of a field
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, frame_buf.size());
      while (frame_buf.size() > cut) void'(frame_buf.pop_back());
    end
    flush_frame();
  endtask

  // ---------------------------------------------------------------------
  // Input driver: holds valid and payload until the transfer completes
  // ---------------------------------------------------------------------
  int unsigned gap_left = 0;
  hdr_byte_t   cur_item;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        scan_byte(header_byte_i, frame_end_i);
        n_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (drv_idle_en && gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (tx_q.size() > 0) begin
          cur_item = tx_q.pop_front();
          in_valid_i    <= 1'b1;
          header_byte_i <= cur_item.hb;
          frame_end_i   <= cur_item.fe;
          if (drv_idle_en && $urandom_range(0, 11) == 0) gap_left = $urandom_range(1, 12);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor and stall generator
  // ---------------------------------------------------------------------
  int unsigned n_results = 0;
  int unsigned stall_left = 0;
  bit          hold_req = 1'b0;
  hfx_result_t want_res;

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // one long hold-off so the output register fills and the input backs up
  initial begin
    wait (n_results >= 12);
    @(posedge clk_i);
    hold_req <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_req <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (summary_q.size() == 0) begin
          $error("result transfer with nothing outstanding");
          n_errors++;
        end else begin
          want_res = summary_q.pop_front();
          check_field("status_code", 64'(want_res.status_code), 64'(status_code_o));
          check_field("status_found", 64'(want_res.status_found), 64'(status_found_o));
          check_field("content_length", 64'(want_res.content_length),
                      64'(content_length_o));
          check_field("length_found", 64'(want_res.length_found), 64'(length_found_o));
          check_field("type_found", 64'(want_res.type_found), 64'(type_found_o));
          check_field("type_closed", 64'(want_res.type_closed), 64'(type_closed_o));
          check_field("type_length", 64'(want_res.type_length), 64'(type_length_o));
          check_field("type_bytes_lo", want_res.type_bytes_lo, type_bytes_lo_o);
          check_field("type_bytes_mid", want_res.type_bytes_mid, type_bytes_mid_o);
          check_field("type_bytes_hi", want_res.type_bytes_hi, type_bytes_hi_o);
        end
      end
      if (hold_req) begin
        out_stall_i <= 1'b1;
      end else if (rcv_idle_en && stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (rcv_idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed buffers, then random phases with drains
  // ---------------------------------------------------------------------
  task automatic drain();
    while (!(n_sent == n_pushed && summary_q.size() == 0)) @(posedge clk_i);
  endtask

  initial begin
    clear_matchers();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no keyword at all
    add_byte(8'hFF);
    flush_frame();
    // status with every whitespace kind, then a sign instead of a digit
    add_str("HTTP ");
    add_byte(8'h09); add_byte(8'h0A); add_byte(8'h0B); add_byte(8'h0C); add_byte(8'h0D);
    add_byte("-");
    flush_frame();
    // type closed by ';' with a single captured byte
    add_str("Content-Type: a;");
    flush_frame();
    drain();

    while (n_pushed < 550) gen_frame();
    drain();

    // a stretch with neither side idling
    drv_idle_en = 1'b0;
    rcv_idle_en = 1'b0;
    while (n_pushed < 850) gen_frame();
    drain();

    drv_idle_en = 1'b1;
    rcv_idle_en = 1'b1;
    while (n_pushed < 1050) gen_frame();
    drain();

    // final part runs without idling
    drv_idle_en = 1'b0;
    rcv_idle_en = 1'b0;
    while (n_pushed < 1200 || n_frames < 40) gen_frame();
    drain();
    repeat (10) @(posedge clk_i);

    if (summary_q.size() != 0) begin
      $error("%0d results never arrived", summary_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

[http_header_field_extractor.f]
hw/rtl/hfx_pkg.sv
hw/rtl/hfx_core.sv
hw/rtl/http_header_field_extractor.sv
hw/rtl/hfx_checker.sv
tb/sv/tb.sv
